// ===== src/ubx_pkg.sv =====
// Shared types and constants for the UBX frame parser.
package ubx_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [1:0] FUNC_FEED   = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_RESYNC = 2'd2;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam int LEN_W      = 16;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        logic [8:0] payload_len;
        logic [7:0] read_data;
    } t_out_item;

endpackage

// ===== src/ubx_parser.sv =====
// Frame state machine, Fletcher checksum, payload store and result register.
module ubx_parser #(
    parameter int MAX_PAYLOAD = ubx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ubx_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output ubx_pkg::t_out_item o_res
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [ubx_pkg::LEN_W-1:0] MAX_LEN = ubx_pkg::LEN_W'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } t_phase;

    t_phase                      r_phase;
    logic [7:0]                  r_class;
    logic [7:0]                  r_id;
    logic [ubx_pkg::LEN_W-1:0]   r_len;
    logic [PW-1:0]               r_pos;
    logic [7:0]                  r_sum_a;
    logic [7:0]                  r_sum_b;

    logic                        r_res_valid;
    logic                        r_res_kind;
    logic [7:0]                  r_res_class;
    logic [7:0]                  r_res_id;
    logic [8:0]                  r_res_len;
    logic [7:0]                  r_rd_data;
    logic                        r_rd_zero;

    logic [7:0]                  r_mem [MAX_PAYLOAD];

    logic                        feed;
    logic [7:0]                  b;
    logic [7:0]                  n_sum_a;
    logic [7:0]                  n_sum_b;
    logic [ubx_pkg::LEN_W-1:0]   n_len;
    logic [PW-1:0]               n_pos;
    logic                        pos_done;
    logic                        rd_in_range;
    logic [AW-1:0]               rd_addr;

    assign feed        = i_accept && (i_item.func == ubx_pkg::FUNC_FEED);
    assign b           = i_item.rx_byte;
    assign n_sum_a     = r_sum_a + b;
    assign n_sum_b     = r_sum_b + n_sum_a;
    assign n_len       = {b, r_len[7:0]};
    assign n_pos       = r_pos + 1'b1;
    assign pos_done    = ubx_pkg::LEN_W'(n_pos) >= r_len;
    assign rd_in_range = int'(i_item.read_index) < MAX_PAYLOAD;
    assign rd_addr     = AW'(i_item.read_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_class     <= '0;
            r_id        <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_accept) begin
                unique case (i_item.func)
                    ubx_pkg::FUNC_FEED: begin
                        unique case (r_phase)
                            PH_SYNC1: begin
                                if (b == ubx_pkg::SYNC_FIRST) r_phase <= PH_SYNC2;
                            end
                            PH_SYNC2: begin
                                r_phase <= (b == ubx_pkg::SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                            end
                            PH_CLASS: begin
                                r_class <= b;
                                r_sum_a <= b;
                                r_sum_b <= b;
                                r_phase <= PH_ID;
                            end
                            PH_ID: begin
                                r_id    <= b;
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_phase <= PH_LEN_LO;
                            end
                            PH_LEN_LO: begin
                                r_len   <= ubx_pkg::LEN_W'(b);
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_phase <= PH_LEN_HI;
                            end
                            PH_LEN_HI: begin
                                r_len   <= n_len;
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_pos   <= '0;
                                // drop oversize frames, skip payload on empty ones
                                if (n_len > MAX_LEN) begin
                                    r_phase <= PH_SYNC1;
                                end else if (n_len == '0) begin
                                    r_phase <= PH_CK_A;
                                end else begin
                                    r_phase <= PH_PAYLOAD;
                                end
                            end
                            PH_PAYLOAD: begin
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_pos   <= n_pos;
                                if (pos_done) r_phase <= PH_CK_A;
                            end
                            PH_CK_A: begin
                                r_phase <= (b == r_sum_a) ? PH_CK_B : PH_SYNC1;
                            end
                            PH_CK_B: begin
                                if (b == r_sum_b) begin
                                    r_res_valid <= 1'b1;
                                    r_res_kind  <= ubx_pkg::KIND_FRAME;
                                    r_res_class <= r_class;
                                    r_res_id    <= r_id;
                                    r_res_len   <= r_len[8:0];
                                end
                                r_phase <= PH_SYNC1;
                            end
                            default: begin
                                r_phase <= PH_SYNC1;
                            end
                        endcase
                    end
                    ubx_pkg::FUNC_READ: begin
                        r_res_valid <= 1'b1;
                        r_res_kind  <= ubx_pkg::KIND_READ;
                        r_res_class <= '0;
                        r_res_id    <= '0;
                        r_res_len   <= '0;
                    end
                    ubx_pkg::FUNC_RESYNC: begin
                        r_phase <= PH_SYNC1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload store: one write or one read per transfer
    always_ff @(posedge i_clk) begin
        if (feed && (r_phase == PH_PAYLOAD)) begin
            r_mem[r_pos[AW-1:0]] <= b;
        end
        if (i_accept && (i_item.func == ubx_pkg::FUNC_READ)) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_zero <= !rd_in_range;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_res.kind        = r_res_kind;
    assign o_res.msg_class   = r_res_class;
    assign o_res.msg_id      = r_res_id;
    assign o_res.payload_len = r_res_len;
    assign o_res.read_data   = ((r_res_kind == ubx_pkg::KIND_READ) && !r_rd_zero)
                               ? r_rd_data : 8'd0;

endmodule

// ===== src/ubx_out_queue.sv =====
// Small output queue that decouples result delivery from the parser.
module ubx_out_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  ubx_pkg::t_out_item        i_push_item,
    input  logic                      i_stall,
    output logic                      o_valid,
    output ubx_pkg::t_out_item        o_item,
    output logic [ubx_pkg::OUTQ_AW:0] o_count
);

    ubx_pkg::t_out_item          r_q [ubx_pkg::OUTQ_DEPTH];
    logic [ubx_pkg::OUTQ_AW-1:0] r_head;
    logic [ubx_pkg::OUTQ_AW:0]   r_cnt;

    logic                        pop;
    logic [ubx_pkg::OUTQ_AW-1:0] tail;

    assign pop  = (r_cnt != '0) && !i_stall;
    assign tail = r_head + r_cnt[ubx_pkg::OUTQ_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            if (pop) r_head <= r_head + 1'b1;
            r_cnt <= r_cnt + (ubx_pkg::OUTQ_AW + 1)'(i_push)
                           - (ubx_pkg::OUTQ_AW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[tail] <= i_push_item;
    end

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_head];
    assign o_count = r_cnt;

endmodule

// ===== src/ubx_frame_parser.sv =====
// UBX frame parser top level: parser core and output queue.
//
//   channel | direction | valid       | stall       | payload
//   input   | in        | i_in_valid  | o_in_stall  | i_in  (t_in_item)
//   output  | out       | o_out_valid | i_out_stall | o_out (t_out_item)
//
// One item is taken per cycle while o_in_stall is low; the parser state update is
// a single registered pass. Results pass the result register and then the queue.
// o_in_stall rises once the result register and the four-entry output queue hold
// four results between them; it comes from registers only.
// Reset is synchronous and active low; it clears the parser and the queue, while
// the payload store keeps its contents.
module ubx_frame_parser #(
    parameter int MAX_PAYLOAD = ubx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ubx_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ubx_pkg::t_out_item o_out
);

    logic                      accept;
    logic                      res_valid;
    ubx_pkg::t_out_item        res;
    logic [ubx_pkg::OUTQ_AW:0] q_count;

    // hold off input while the queue could not absorb another result
    assign o_in_stall = (q_count + (ubx_pkg::OUTQ_AW + 1)'(res_valid))
                        >= (ubx_pkg::OUTQ_AW + 1)'(ubx_pkg::OUTQ_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    ubx_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    ubx_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_push_item(res),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_item     (o_out),
        .o_count    (q_count)
    );

endmodule

// ===== src/ubx_checker.sv =====
// Port-level assertions for the UBX frame parser, bound to the top level.
module ubx_checker #(
    parameter int MAX_PAYLOAD = ubx_pkg::MAX_PAYLOAD_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ubx_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ubx_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output transfer changed");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == ubx_pkg::KIND_READ) |->
            (o_out.msg_class == 8'd0) && (o_out.msg_id == 8'd0)
            && (o_out.payload_len == 9'd0))
        else $error("read result carries frame fields");

    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == ubx_pkg::KIND_FRAME) |->
            (o_out.read_data == 8'd0) && (int'(o_out.payload_len) <= MAX_PAYLOAD))
        else $error("frame result has bad length or read data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_no_result_without_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && $past(!i_in_valid || o_in_stall)
            && $past(!i_in_valid || o_in_stall, 2) |-> ##1 !o_out_valid)
        else $error("result appeared with no input transfer");

endmodule

bind ubx_frame_parser ubx_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
) u_ubx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);

// ===== test/ubx_frame_parser_tb.sv =====
// Self-checking testbench for the UBX frame parser: frames, faults, resyncs and payload reads.
`timescale 1ns / 100ps

module ubx_frame_parser_tb;
    import ubx_pkg::*;

    localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
    localparam int MEM_AW       = $clog2(MAX_PAYLOAD);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 520;
    localparam int DRAIN_CYCLES = 12;
    localparam int SHOW_LIMIT   = 10;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    typedef enum logic [3:0] {
        HUNT_B5, HUNT_62, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
        GET_PAYLOAD, GET_CK_A, GET_CK_B
    } t_parse_phase;

    typedef enum int {
        FLAW_NONE, FLAW_SYNC2, FLAW_CK_A, FLAW_CK_B, FLAW_RESYNC, FLAW_CUT
    } t_flaw;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    // Parser state as predicted by the testbench
    t_parse_phase parse_phase = HUNT_B5;
    logic [7:0]   cur_class   = '0;
    logic [7:0]   cur_id      = '0;
    logic [15:0]  cur_len     = '0;
    logic [15:0]  cur_pos     = '0;
    logic [7:0]   run_a       = '0;
    logic [7:0]   run_b       = '0;
    logic [7:0]   payload_mem [MAX_PAYLOAD];
    int           store_fill  = 0;

    t_out_item pending_results[$];
    t_out_item want;

    int unsigned cycle_count   = 0;
    int          items_sent    = 0;
    int          ignored_items = 0;
    int          faults_sent   = 0;
    int          error_count   = 0;
    int          frames_seen   = 0;
    int          reads_seen    = 0;
    int          burst_left    = 0;
    int          stall_left    = 0;
    int          stall_mode    = 0;

    ubx_frame_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("ubx_frame_parser_tb: done, errors");
            $finish;
        end
    end

    // Receiver backpressure: switch between no stall, light, heavy and periodic stall
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(40, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= cycle_count[2];
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= SHOW_LIMIT)
                    $display({"ERROR cycle %0d: unexpected result kind %0d class %02h",
                              " id %02h len %0d data %02h"},
                             cycle_count, o_out.kind, o_out.msg_class, o_out.msg_id,
                             o_out.payload_len, o_out.read_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out.kind !== want.kind || o_out.msg_class !== want.msg_class ||
                    o_out.msg_id !== want.msg_id || o_out.payload_len !== want.payload_len ||
                    o_out.read_data !== want.read_data) begin
                    error_count++;
                    if (error_count <= SHOW_LIMIT)
                        $display({"ERROR cycle %0d: expected kind %0d class %02h id %02h",
                                  " len %0d data %02h, got kind %0d class %02h id %02h",
                                  " len %0d data %02h"},
                                 cycle_count, want.kind, want.msg_class, want.msg_id,
                                 want.payload_len, want.read_data, o_out.kind,
                                 o_out.msg_class, o_out.msg_id, o_out.payload_len,
                                 o_out.read_data);
                end else if (want.kind == KIND_FRAME) begin
                    frames_seen++;
                end else begin
                    reads_seen++;
                end
            end
        end
    end

    // Advance the predicted parser by one accepted item and queue any result
    task automatic parser_predict(input t_in_item it);
        t_out_item  res;
        logic [7:0] b;
        logic       fold;
        res  = '0;
        b    = it.rx_byte;
        fold = 1'b0;
        case (it.func)
            FUNC_FEED: begin
                case (parse_phase)
                    HUNT_B5: if (b == SYNC_FIRST) parse_phase = HUNT_62;
                    HUNT_62: parse_phase = (b == SYNC_SECOND) ? GET_CLASS : HUNT_B5;
                    GET_CLASS: begin
                        cur_class   = b;
                        run_a       = '0;
                        run_b       = '0;
                        fold        = 1'b1;
                        parse_phase = GET_ID;
                    end
                    GET_ID: begin
                        cur_id      = b;
                        fold        = 1'b1;
                        parse_phase = GET_LEN_LO;
                    end
                    GET_LEN_LO: begin
                        cur_len     = {8'h00, b};
                        fold        = 1'b1;
                        parse_phase = GET_LEN_HI;
                    end
                    GET_LEN_HI: begin
                        cur_len[15:8] = b;
                        fold          = 1'b1;
                        cur_pos       = '0;
                        if (cur_len > MAX_PAYLOAD)
                            parse_phase = HUNT_B5;
                        else if (cur_len == 0)
                            parse_phase = GET_CK_A;
                        else
                            parse_phase = GET_PAYLOAD;
                    end
                    GET_PAYLOAD: begin
                        if (cur_pos < MAX_PAYLOAD) begin
                            payload_mem[cur_pos[MEM_AW-1:0]] = b;
                            if (cur_pos >= store_fill) store_fill = cur_pos + 1;
                        end
                        fold    = 1'b1;
                        cur_pos = cur_pos + 16'd1;
                        if (cur_pos >= cur_len) parse_phase = GET_CK_A;
                    end
                    GET_CK_A: parse_phase = (b == run_a) ? GET_CK_B : HUNT_B5;
                    GET_CK_B: begin
                        if (b == run_b) begin
                            res.kind        = KIND_FRAME;
                            res.msg_class   = cur_class;
                            res.msg_id      = cur_id;
                            res.payload_len = cur_len[8:0];
                            pending_results.push_back(res);
                        end
                        parse_phase = HUNT_B5;
                    end
                    default: parse_phase = HUNT_B5;
                endcase
                if (fold) begin
                    run_a = run_a + b;
                    run_b = run_b + run_a;
                end
            end
            FUNC_READ: begin
                res.kind      = KIND_READ;
                res.read_data = (it.read_index < MAX_PAYLOAD) ? payload_mem[it.read_index] : '0;
                pending_results.push_back(res);
            end
            FUNC_RESYNC: parse_phase = HUNT_B5;
            default: ;
        endcase
    endtask

    // Present one item in bursts with random gaps and hold it until the transfer
    task automatic push_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        parser_predict(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.func       = FUNC_FEED;
        it.rx_byte    = b;
        it.read_index = 8'($urandom);
        push_item(it);
    endtask

    task automatic send_read(input logic [7:0] idx);
        t_in_item it;
        it.func       = FUNC_READ;
        it.rx_byte    = 8'($urandom);
        it.read_index = idx;
        push_item(it);
    endtask

    task automatic send_control(input logic [1:0] f);
        t_in_item it;
        it.func       = f;
        it.rx_byte    = 8'($urandom);
        it.read_index = 8'($urandom);
        push_item(it);
    endtask

    // Read only entries already written; writes always fill the store from index zero
    task automatic send_stored_read();
        int pick;
        if (store_fill > 0) begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                send_read(8'd0);
            else if (pick == 1)
                send_read(8'(store_fill - 1));
            else
                send_read(8'($urandom_range(0, store_fill - 1)));
        end
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input t_flaw flaw, input bit mix);
        logic [7:0] bytes[$];
        logic [7:0] a;
        logic [7:0] s;
        logic [7:0] other;
        int         cut;
        other = 8'($urandom);
        if (other == SYNC_SECOND) other = ~other;
        bytes.push_back(SYNC_FIRST);
        bytes.push_back((flaw == FLAW_SYNC2) ? other : SYNC_SECOND);
        bytes.push_back(cls);
        bytes.push_back(id);
        bytes.push_back(len[7:0]);
        bytes.push_back(len[15:8]);
        if (len <= MAX_PAYLOAD) begin
            repeat (len) bytes.push_back(8'($urandom));
            a = '0;
            s = '0;
            for (int i = 2; i < bytes.size(); i++) begin
                a = a + bytes[i];
                s = s + a;
            end
            if (flaw == FLAW_CK_A) a = a ^ 8'($urandom_range(1, 255));
            if (flaw == FLAW_CK_B) s = s ^ 8'($urandom_range(1, 255));
            bytes.push_back(a);
            bytes.push_back(s);
        end
        cut = bytes.size();
        if (flaw == FLAW_RESYNC || flaw == FLAW_CUT) cut = $urandom_range(2, bytes.size() - 1);
        for (int i = 0; i < cut; i++) begin
            // slip reads in between frame bytes to hit the store while it is rewritten
            if (mix && $urandom_range(0, 11) == 0) send_stored_read();
            send_byte(bytes[i]);
        end
        if (flaw == FLAW_RESYNC) send_control(FUNC_RESYNC);
        if (flaw != FLAW_NONE || len > MAX_PAYLOAD) faults_sent++;
    endtask

    task automatic test_zero_length_frame();
        send_frame(8'h00, 8'hFF, 16'd0, FLAW_NONE, 1'b0);
    endtask

    task automatic test_sync_and_checksum_faults();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_frame(8'hFF, 8'h00, 16'd0, FLAW_CK_A, 1'b0);
        send_frame(8'h5A, 8'hA5, 16'd0, FLAW_CK_B, 1'b0);
    endtask

    task automatic test_oversize_length();
        send_frame(8'h01, 8'h07, 16'(MAX_PAYLOAD + 1), FLAW_NONE, 1'b0);
    endtask

    task automatic test_resync_and_unused_func();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_control(FUNC_RESYNC);
        send_control(FUNC_NOP);
        send_byte(SYNC_SECOND);
    endtask

    task automatic test_payload_read();
        send_frame(8'h80, 8'h7F, 16'd1, FLAW_NONE, 1'b0);
        send_read(8'd0);
    endtask

    task automatic test_random_traffic();
        int          start;
        int          r;
        int          n;
        logic [15:0] len;
        t_flaw       flaw;
        start = items_sent;
        // fill the whole store once so every read index becomes legal
        send_frame(8'($urandom), 8'($urandom), 16'(MAX_PAYLOAD), FLAW_NONE, 1'b1);
        send_read(8'(MAX_PAYLOAD - 1));
        while (items_sent - start - ignored_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 11) begin
                r = $urandom_range(0, 39);
                if (r == 0)
                    len = 16'($urandom_range(MAX_PAYLOAD - 6, MAX_PAYLOAD));
                else if (r < 6)
                    len = 16'd0;
                else
                    len = 16'($urandom_range(1, 12));
                r = $urandom_range(0, 15);
                case (r)
                    10: flaw = FLAW_CK_A;
                    11: flaw = FLAW_CK_B;
                    12: flaw = FLAW_RESYNC;
                    13: flaw = FLAW_CUT;
                    14: flaw = FLAW_SYNC2;
                    default: flaw = FLAW_NONE;
                endcase
                if (r == 15)
                    len = ($urandom_range(0, 3) == 0)
                          ? 16'hFFFF
                          : 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
                send_frame(8'($urandom), 8'($urandom), len, flaw, 1'b1);
            end else if (r < 15) begin
                repeat ($urandom_range(1, 4)) send_stored_read();
            end else if (r < 18) begin
                n = $urandom_range(1, 6);
                ignored_items += n;
                repeat (n) send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
            end else begin
                ignored_items++;
                send_control((r == 18) ? FUNC_RESYNC : FUNC_NOP);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length_frame();
        test_sync_and_checksum_faults();
        test_oversize_length();
        test_resync_and_unused_func();
        test_payload_read();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d items sent, %0d faulty or oversize frames among them",
                 items_sent, faults_sent);
        $display("summary: %0d frames and %0d payload reads checked, %0d errors",
                 frames_seen, reads_seen, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ubx_frame_parser_tb: done, clean");
        end else begin
            $display("ubx_frame_parser_tb: done, errors");
        end
        $finish;
    end

endmodule
